### hdl/vpts_pkg.sv
package vpts_pkg;

   localparam int COEF_FRAC   = 10;
   localparam int POS_FRAC    = 16;
   localparam int SCREEN_BITS = 12;
   localparam int NDC_SAT     = 4;

   localparam int POS_W   = 32;
   localparam int COEF_W  = 16;
   localparam int PROD_W  = POS_W + COEF_W;
   localparam int CLIP_W  = 51;
   localparam int MAG_W   = CLIP_W;
   localparam int R_W     = MAG_W + 2;
   localparam int Q_W     = POS_FRAC + 2;
   localparam int NDC_W   = Q_W + 1;
   localparam int V_W     = NDC_W + 2;
   localparam int SIZE_W  = 13;
   localparam int T_W     = V_W + SIZE_W + 1;
   localparam int PX_W    = T_W - POS_FRAC - 1;

   localparam int DIV_STAGES = Q_W;
   localparam int DIV_FIRST  = 4;
   localparam int NSTG       = DIV_FIRST + DIV_STAGES + 3;

   localparam logic [NDC_W-1:0] NDC_LIM = NDC_W'(NDC_SAT) << POS_FRAC;

   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   localparam logic [2:0] REG_ROW0   = 3'd0;
   localparam logic [2:0] REG_ROW1   = 3'd1;
   localparam logic [2:0] REG_ROW2   = 3'd2;
   localparam logic [2:0] REG_ROW3   = 3'd3;
   localparam logic [2:0] REG_WIDTH  = 3'd4;
   localparam logic [2:0] REG_HEIGHT = 3'd5;

   typedef struct packed {
      logic [R_W-1:0]   rx;
      logic [R_W-1:0]   ry;
      logic [Q_W-1:0]   qx;
      logic [Q_W-1:0]   qy;
      logic [MAG_W-1:0] b;
   } div_type;

   typedef struct packed {
      logic             wz;
      logic             negx;
      logic             negy;
      logic             satx;
      logic             saty;
      logic [NDC_W-1:0] zx;
      logic [NDC_W-1:0] zy;
   } side_type;

endpackage

### hdl/vertex_project_to_screen.sv
// Vertex projection to screen pixels.
// Input items arrive on req_ (tdata: pos_x, pos_y, pos_z, signed Q16.16).
// Each is multiplied as (x,y,z,1) by the 4x4 matrix in csr rows 0..3, clip
// x and y are divided by clip w and mapped to the viewport set by the width
// and height registers. Results leave on rsp_ (tdata: screen_x, screen_y;
// tuser: w_was_zero).
// The stages are one multiply stage, one sum stage, two sign and
// range stages, 18 restoring divide stages (one quotient bit each), then
// offset, scale and clamp stages. One item enters per cycle unless stalled.
// Every stage has its own valid bit and stalls only when it is full and
// the stage after it cannot move, so bubbles close up while rsp_tready is
// low and no item is lost or repeated. req_tready falls only when the whole
// pipe is full and the receiver stalls.
// Reset empties the pipe and returns the matrix to identity and the
// viewport to 640x480. Write registers only while the pipe is empty.
module vertex_project_to_screen (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // pos_x, pos_y, pos_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // screen_x, screen_y
   output logic        rsp_tuser,   // w_was_zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [vpts_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [vpts_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [vpts_pkg::CSR_DW-1:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NS = vpts_pkg::NSTG;
   localparam int DS = vpts_pkg::DIV_STAGES;
   localparam int D0 = vpts_pkg::DIV_FIRST;

   logic [63:0] row_ff [4];
   logic [vpts_pkg::SIZE_W-1:0] width_ff, height_ff;
   logic [2:0] csr_idx;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[5:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= 64'd1024;
         row_ff[1] <= 64'd1024 << 16;
         row_ff[2] <= 64'd1024 << 32;
         row_ff[3] <= 64'd1024 << 48;
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
      end else if (csr_wr) begin
         case (csr_idx)
            vpts_pkg::REG_ROW0:   row_ff[0] <= csr_pwdata;
            vpts_pkg::REG_ROW1:   row_ff[1] <= csr_pwdata;
            vpts_pkg::REG_ROW2:   row_ff[2] <= csr_pwdata;
            vpts_pkg::REG_ROW3:   row_ff[3] <= csr_pwdata;
            vpts_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[vpts_pkg::SIZE_W-1:0];
            vpts_pkg::REG_HEIGHT: height_ff <= csr_pwdata[vpts_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         vpts_pkg::REG_ROW0:   csr_prdata = row_ff[0];
         vpts_pkg::REG_ROW1:   csr_prdata = row_ff[1];
         vpts_pkg::REG_ROW2:   csr_prdata = row_ff[2];
         vpts_pkg::REG_ROW3:   csr_prdata = row_ff[3];
         vpts_pkg::REG_WIDTH:  csr_prdata = 64'(width_ff);
         vpts_pkg::REG_HEIGHT: csr_prdata = 64'(height_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // pipeline valid chain
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? req_tvalid : v_ff[k == 0 ? 0 : k - 1];
            end
         end
      end
   end

   // stage 0: products for columns x, y, w
   logic signed [vpts_pkg::POS_W-1:0] pos [3];
   logic signed [vpts_pkg::PROD_W-1:0] prod_ff [3][3];
   logic signed [vpts_pkg::POS_W-1:0]  tr_ff [3];
   logic [1:0] colsel [3];

   assign pos[0] = req_tdata[31:0];
   assign pos[1] = req_tdata[63:32];
   assign pos[2] = req_tdata[95:64];
   assign colsel[0] = 2'd0;
   assign colsel[1] = 2'd1;
   assign colsel[2] = 2'd3;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               prod_ff[c][r] <= pos[r] *
                  $signed(row_ff[r][16*colsel[c] +: vpts_pkg::COEF_W]);
            end
            tr_ff[c] <= {row_ff[3][16*colsel[c] +: vpts_pkg::COEF_W],
                         {vpts_pkg::POS_FRAC{1'b0}}};
         end
      end
   end

   // stage 1: clip sums
   logic signed [vpts_pkg::CLIP_W-1:0] clip_ff [3];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int c = 0; c < 3; c++) begin
            clip_ff[c] <= vpts_pkg::CLIP_W'(prod_ff[c][0])
                        + vpts_pkg::CLIP_W'(prod_ff[c][1])
                        + vpts_pkg::CLIP_W'(prod_ff[c][2])
                        + vpts_pkg::CLIP_W'(tr_ff[c]);
         end
      end
   end

   // stage 2: signs and magnitudes
   logic [vpts_pkg::MAG_W-1:0] mag_ff [3];
   logic [2:0] sgn_ff;
   logic       wz_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int c = 0; c < 3; c++) begin
            sgn_ff[c] <= clip_ff[c][vpts_pkg::CLIP_W-1];
            mag_ff[c] <= clip_ff[c][vpts_pkg::CLIP_W-1] ?
                         vpts_pkg::MAG_W'(-clip_ff[c]) : vpts_pkg::MAG_W'(clip_ff[c]);
         end
         wz_ff <= (clip_ff[2] == '0);
      end
   end

   // stage 3: range check and zero-w path
   vpts_pkg::div_type  dinit_in, dinit_ff;
   vpts_pkg::side_type sinit_in, sinit_ff;
   logic [vpts_pkg::R_W-1:0] four_b;
   logic [vpts_pkg::MAG_W-1:0] zsx, zsy;

   always_comb begin
      four_b = vpts_pkg::R_W'(mag_ff[2]) << 2;
      zsx    = mag_ff[0] >> vpts_pkg::COEF_FRAC;
      zsy    = mag_ff[1] >> vpts_pkg::COEF_FRAC;
      dinit_in.rx = vpts_pkg::R_W'(mag_ff[0]);
      dinit_in.ry = vpts_pkg::R_W'(mag_ff[1]);
      dinit_in.qx = '0;
      dinit_in.qy = '0;
      dinit_in.b  = mag_ff[2];
      sinit_in.wz   = wz_ff;
      sinit_in.negx = wz_ff ? sgn_ff[0] : (sgn_ff[0] ^ sgn_ff[2]);
      sinit_in.negy = wz_ff ? sgn_ff[1] : (sgn_ff[1] ^ sgn_ff[2]);
      sinit_in.satx = vpts_pkg::R_W'(mag_ff[0]) >= four_b;
      sinit_in.saty = vpts_pkg::R_W'(mag_ff[1]) >= four_b;
      sinit_in.zx   = (zsx > vpts_pkg::MAG_W'(vpts_pkg::NDC_LIM)) ?
                      vpts_pkg::NDC_LIM : zsx[vpts_pkg::NDC_W-1:0];
      sinit_in.zy   = (zsy > vpts_pkg::MAG_W'(vpts_pkg::NDC_LIM)) ?
                      vpts_pkg::NDC_LIM : zsy[vpts_pkg::NDC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         dinit_ff <= dinit_in;
         sinit_ff <= sinit_in;
      end
   end

   // stages 4..21: one quotient bit per stage for x and y
   vpts_pkg::div_type  div_ff [DS];
   vpts_pkg::div_type  div_in [DS];
   vpts_pkg::side_type side_ff [DS];

   always_comb begin
      vpts_pkg::div_type src;
      logic [vpts_pkg::R_W-1:0] d, rx, ry;
      logic bx, by;
      for (int s = 0; s < DS; s++) begin
         src = (s == 0) ? dinit_ff : div_ff[s == 0 ? 0 : s - 1];
         if (s < 2) begin
            d  = vpts_pkg::R_W'(src.b) << (1 - s);
            rx = src.rx;
            ry = src.ry;
         end else begin
            d  = vpts_pkg::R_W'(src.b);
            rx = src.rx << 1;
            ry = src.ry << 1;
         end
         bx = rx >= d;
         by = ry >= d;
         div_in[s].rx = bx ? rx - d : rx;
         div_in[s].ry = by ? ry - d : ry;
         div_in[s].qx = {src.qx[vpts_pkg::Q_W-2:0], bx};
         div_in[s].qy = {src.qy[vpts_pkg::Q_W-2:0], by};
         div_in[s].b  = src.b;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DS; s++) begin
         if (en[D0 + s]) begin
            div_ff[s]  <= div_in[s];
            side_ff[s] <= (s == 0) ? sinit_ff : side_ff[s == 0 ? 0 : s - 1];
         end
      end
   end

   // stage 22: select ndc and offset
   localparam int NB = D0 + DS;
   vpts_pkg::side_type sl;
   logic [vpts_pkg::NDC_W-1:0] mx, my;
   logic signed [vpts_pkg::V_W-1:0] nx, ny, one;
   logic signed [vpts_pkg::V_W-1:0] vx_ff, vy_ff;
   logic wz2_ff, wz3_ff;

   always_comb begin
      sl  = side_ff[DS-1];
      one = vpts_pkg::V_W'(1) << vpts_pkg::POS_FRAC;
      mx  = sl.wz ? sl.zx : sl.satx ? vpts_pkg::NDC_LIM :
            vpts_pkg::NDC_W'(div_ff[DS-1].qx);
      my  = sl.wz ? sl.zy : sl.saty ? vpts_pkg::NDC_LIM :
            vpts_pkg::NDC_W'(div_ff[DS-1].qy);
      nx  = sl.negx ? -vpts_pkg::V_W'(mx) : vpts_pkg::V_W'(mx);
      ny  = sl.negy ? -vpts_pkg::V_W'(my) : vpts_pkg::V_W'(my);
   end

   always_ff @(posedge clock) begin
      if (en[NB]) begin
         vx_ff  <= one + nx;
         vy_ff  <= one - ny;
         wz2_ff <= sl.wz;
      end
   end

   // stage 23: scale by viewport size
   logic signed [vpts_pkg::T_W-1:0] tx_ff, ty_ff;

   always_ff @(posedge clock) begin
      if (en[NB + 1]) begin
         tx_ff  <= vx_ff * $signed({1'b0, width_ff});
         ty_ff  <= vy_ff * $signed({1'b0, height_ff});
         wz3_ff <= wz2_ff;
      end
   end

   // stage 24: floor and clamp
   logic [vpts_pkg::SCREEN_BITS-1:0] sx_in, sy_in, sx_ff, sy_ff;
   logic wzo_ff;

   function automatic logic [vpts_pkg::SCREEN_BITS-1:0] clamp_px(
      input logic signed [vpts_pkg::T_W-1:0] t,
      input logic [vpts_pkg::SIZE_W-1:0] size
   );
      logic [vpts_pkg::SIZE_W-1:0] lim;
      logic [vpts_pkg::PX_W-1:0] px;
      lim = (size == '0) ? '0 : size - 1'b1;
      if (lim > vpts_pkg::SIZE_W'({vpts_pkg::SCREEN_BITS{1'b1}})) begin
         lim = vpts_pkg::SIZE_W'({vpts_pkg::SCREEN_BITS{1'b1}});
      end
      px = t[vpts_pkg::T_W-1 -: vpts_pkg::PX_W];
      if (t[vpts_pkg::T_W-1]) begin
         clamp_px = '0;
      end else if (px > vpts_pkg::PX_W'(lim)) begin
         clamp_px = vpts_pkg::SCREEN_BITS'(lim);
      end else begin
         clamp_px = vpts_pkg::SCREEN_BITS'(px);
      end
   endfunction

   assign sx_in = clamp_px(tx_ff, width_ff);
   assign sy_in = clamp_px(ty_ff, height_ff);

   always_ff @(posedge clock) begin
      if (en[NB + 2]) begin
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         wzo_ff <= wz3_ff;
      end
   end

   assign rsp_tvalid = v_ff[NS-1];
   assign rsp_tdata  = {sy_ff, sx_ff};
   assign rsp_tuser  = wzo_ff;

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[0])
      else $error("accepted item did not enter the pipe");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !rsp_tready |-> !req_tready)
      else $error("full pipe took an item while stalled");

   a_rem: assert property (@(posedge clock) disable iff (reset)
      v_ff[NB-1] && !side_ff[DS-1].wz |->
         (side_ff[DS-1].satx || div_ff[DS-1].rx < vpts_pkg::R_W'(div_ff[DS-1].b)) &&
         (side_ff[DS-1].saty || div_ff[DS-1].ry < vpts_pkg::R_W'(div_ff[DS-1].b)))
      else $error("divide remainder not below divisor");

endmodule
